>>> rtl/core/sfdr_pkg.sv
`default_nettype none

package sfdr_pkg;

	// Field widths.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 6;

	// Longest frame the length field can describe.
	localparam int unsigned MAX_LEN = 63;

	// Configuration register indexes.
	localparam logic [1:0] REG_FRAME_MODE = 2'd0;
	localparam logic [1:0] REG_HEADER     = 2'd1;
	localparam logic [1:0] REG_MIN_LEN    = 2'd2;
	localparam logic [1:0] REG_FIXED_LEN  = 2'd3;

	// Register reset values.
	localparam logic [7:0] HEADER_RESET    = 8'hAA;
	localparam logic [5:0] MIN_LEN_RESET   = 6'd4;
	localparam logic [5:0] FIXED_LEN_RESET = 6'd8;

	// Input kinds on the slave side.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POLL = 1'b1;

	// Result kinds on the master side.
	localparam logic KIND_NONE  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	// Frame modes.
	localparam logic MODE_VARIABLE = 1'b0;
	localparam logic MODE_FIXED    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_HDR,
		ST_LEN,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_NONE
	} state_t;

	// Command from the parser to the ring buffer.
	typedef struct packed {
		logic              push;
		logic [BYTE_W-1:0] wdata;
		logic              skip;
		logic [LEN_W-1:0]  skip_n;
	} ring_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/sfdr_ring.sv
`default_nettype none

module sfdr_ring #(
	parameter int unsigned BUF_DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire sfdr_pkg::ring_cmd_t                cmd,
	input  wire logic [sfdr_pkg::LEN_W-1:0]         rd_off,
	output logic      [sfdr_pkg::BYTE_W-1:0]        rd_data,
	output logic      [$clog2(BUF_DEPTH)-1:0]       fill
);

	localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
	localparam int unsigned W2    = PTR_W + 1;

	logic [sfdr_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
	logic [PTR_W-1:0]            rp_q;
	logic [PTR_W-1:0]            wp_q;
	logic [PTR_W-1:0]            rd_addr;
	logic [sfdr_pkg::BYTE_W-1:0] rd_data_q;
	logic [W2-1:0]               fill_w;

	// Reduce a sum of a pointer and an offset below the depth.
	function automatic logic [PTR_W-1:0] wrap(input logic [W2-1:0] s);
		logic [W2-1:0] r;
		r = (s >= W2'(BUF_DEPTH)) ? (s - W2'(BUF_DEPTH)) : s;
		return r[PTR_W-1:0];
	endfunction

	// Read address relative to the read pointer.
	assign rd_addr = wrap(W2'(rp_q) + W2'(rd_off));

	// Number of bytes held.
	assign fill_w = W2'(wp_q) - W2'(rp_q) + ((wp_q < rp_q) ? W2'(BUF_DEPTH) : W2'(0));
	assign fill   = fill_w[PTR_W-1:0];

	// Pointer updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			wp_q <= '0;
		end else begin
			if (cmd.push) begin
				wp_q <= wrap(W2'(wp_q) + W2'(1));
			end
			if (cmd.skip) begin
				rp_q <= wrap(W2'(rp_q) + W2'(cmd.skip_n));
			end
		end
	end

	// Storage with one write and one registered read.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp_q] <= cmd.wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/core/serial_frame_deframer_ring.sv
`default_nettype none

// Serial frame deframer. Each slave transfer either pushes one received byte
// into a circular buffer of BUF_DEPTH-1 usable bytes (tuser 0) or only polls
// (tuser 1); then one attempt is made to find a frame at the read pointer. A
// frame opens with the header byte; its length is the byte after the header
// (variable mode) or the fixed length register (fixed mode), and its 8-bit
// additive checksum is the last byte (variable) or the second-last (fixed).
// A bad header, bad length or bad checksum drops one byte; too few bytes
// waits. An attempt with no frame gives one result of kind 0; a found frame
// is removed and sent one byte per result, header first, with tlast on the
// final one. The buffer has a single registered read port, so the checksum
// walk and the frame output each read a byte in a read state (SUM_RD,
// EMIT_RD) before using it. Any stall on the master side holds the
// sequencer in its result states. A byte pushed into a full buffer is
// discarded and flagged on every result of that item. No clearing pass
// follows reset.
module serial_frame_deframer_ring #(
	parameter int unsigned BUF_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] action
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] frame_byte, [13:8] frame_len,
	                                    // [14] byte_dropped, [15] zero
	output logic             m_tlast,   // frame_last
	output logic             m_tuser    // [0] kind
);

	localparam int unsigned PTR_W = $clog2(BUF_DEPTH);
	localparam int unsigned CW    = ((PTR_W > 8) ? PTR_W : 8) + 1;

	localparam int unsigned BW = sfdr_pkg::BYTE_W;
	localparam int unsigned LW = sfdr_pkg::LEN_W;

	sfdr_pkg::state_t    state_q, state_d;
	sfdr_pkg::ring_cmd_t cmd;

	logic [LW-1:0]    rd_off;
	logic [BW-1:0]    rdata;
	logic [PTR_W-1:0] fill;

	// Configuration registers.
	logic          mode_q;
	logic [BW-1:0] header_q;
	logic [LW-1:0] min_len_q;
	logic [LW-1:0] fixed_len_q;

	// Parse registers.
	logic [LW-1:0] len_q, len_d;
	logic [LW-1:0] ck_q, ck_d;
	logic [LW-1:0] off_q, off_d;
	logic [BW-1:0] sum_q, sum_d;
	logic          dropped_q;

	// Output register.
	logic          out_valid_q;
	logic          out_kind_q;
	logic [BW-1:0] out_byte_q;
	logic          out_last_q;
	logic [LW-1:0] out_len_q;
	logic          out_drop_q;

	logic          s_acc;
	logic          full;
	logic          slot_free;
	logic          ld_out;
	logic          ld_kind;
	logic          ld_last;
	logic [LW-1:0] need;

	// Valid frame length: at least two bytes, fits the buffer and the field.
	function automatic logic len_ok(input logic [BW-1:0] n);
		return (n >= BW'(2)) && (CW'(n) <= CW'(BUF_DEPTH - 1))
			&& (CW'(n) <= CW'(sfdr_pkg::MAX_LEN));
	endfunction

	sfdr_ring #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_off (rd_off),
		.rd_data(rdata),
		.fill   (fill)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == sfdr_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign full      = (CW'(fill) >= CW'(BUF_DEPTH - 1));
	assign slot_free = !out_valid_q || m_tready;
	assign need      = (min_len_q < LW'(2)) ? LW'(2) : min_len_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sfdr_pkg::MODE_VARIABLE;
			header_q    <= sfdr_pkg::HEADER_RESET;
			min_len_q   <= sfdr_pkg::MIN_LEN_RESET;
			fixed_len_q <= sfdr_pkg::FIXED_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfdr_pkg::REG_FRAME_MODE: mode_q      <= cfg_data[0];
				sfdr_pkg::REG_HEADER:     header_q    <= cfg_data;
				sfdr_pkg::REG_MIN_LEN:    min_len_q   <= cfg_data[LW-1:0];
				sfdr_pkg::REG_FIXED_LEN:  fixed_len_q <= cfg_data[LW-1:0];
				default:                  ;
			endcase
		end
	end

	// Sequencer: next state, ring commands and datapath updates.
	always_comb begin
		state_d    = state_q;
		cmd.push   = 1'b0;
		cmd.wdata  = s_tdata;
		cmd.skip   = 1'b0;
		cmd.skip_n = LW'(1);
		rd_off     = off_q;
		len_d      = len_q;
		ck_d       = ck_q;
		off_d      = off_q;
		sum_d      = sum_q;
		ld_out     = 1'b0;
		ld_kind    = sfdr_pkg::KIND_NONE;
		ld_last    = 1'b1;
		unique case (state_q)
			sfdr_pkg::ST_IDLE: begin
				if (s_acc) begin
					cmd.push = (s_tuser == sfdr_pkg::ACT_PUSH) && !full;
					state_d  = sfdr_pkg::ST_CHECK;
				end
			end
			sfdr_pkg::ST_CHECK: begin
				// Enough bytes held to look at the header; read offset zero.
				rd_off = '0;
				if (mode_q == sfdr_pkg::MODE_VARIABLE) begin
					state_d = (CW'(fill) < CW'(need)) ? sfdr_pkg::ST_NONE
						: sfdr_pkg::ST_HDR;
				end else begin
					state_d = ((CW'(fill) < CW'(fixed_len_q)) || (fill == '0))
						? sfdr_pkg::ST_NONE : sfdr_pkg::ST_HDR;
				end
			end
			sfdr_pkg::ST_HDR: begin
				// Header byte is on the read data; read the length byte next.
				rd_off = LW'(1);
				if (rdata != header_q) begin
					cmd.skip = 1'b1;
					state_d  = sfdr_pkg::ST_NONE;
				end else if (mode_q == sfdr_pkg::MODE_VARIABLE) begin
					state_d = sfdr_pkg::ST_LEN;
				end else if (!len_ok(BW'(fixed_len_q))) begin
					cmd.skip = 1'b1;
					state_d  = sfdr_pkg::ST_NONE;
				end else begin
					len_d   = fixed_len_q;
					ck_d    = fixed_len_q - LW'(2);
					off_d   = '0;
					sum_d   = '0;
					state_d = sfdr_pkg::ST_SUM_RD;
				end
			end
			sfdr_pkg::ST_LEN: begin
				if (!len_ok(rdata)) begin
					cmd.skip = 1'b1;
					state_d  = sfdr_pkg::ST_NONE;
				end else if (CW'(fill) < CW'(rdata)) begin
					state_d = sfdr_pkg::ST_NONE;
				end else begin
					len_d   = rdata[LW-1:0];
					ck_d    = rdata[LW-1:0] - LW'(1);
					off_d   = '0;
					sum_d   = '0;
					state_d = sfdr_pkg::ST_SUM_RD;
				end
			end
			sfdr_pkg::ST_SUM_RD: begin
				state_d = sfdr_pkg::ST_SUM_ACC;
			end
			sfdr_pkg::ST_SUM_ACC: begin
				// Accumulate bytes up to the checksum position, then compare.
				if (off_q == ck_q) begin
					if (sum_q == rdata) begin
						off_d   = '0;
						state_d = sfdr_pkg::ST_EMIT_RD;
					end else begin
						cmd.skip = 1'b1;
						state_d  = sfdr_pkg::ST_NONE;
					end
				end else begin
					sum_d   = sum_q + rdata;
					off_d   = off_q + LW'(1);
					state_d = sfdr_pkg::ST_SUM_RD;
				end
			end
			sfdr_pkg::ST_EMIT_RD: begin
				state_d = sfdr_pkg::ST_EMIT_OUT;
			end
			sfdr_pkg::ST_EMIT_OUT: begin
				// Hand one frame byte to the output register when it is free.
				if (slot_free) begin
					ld_out  = 1'b1;
					ld_kind = sfdr_pkg::KIND_FRAME;
					ld_last = (off_q == len_q - LW'(1));
					if (ld_last) begin
						cmd.skip   = 1'b1;
						cmd.skip_n = len_q;
						state_d    = sfdr_pkg::ST_IDLE;
					end else begin
						off_d   = off_q + LW'(1);
						state_d = sfdr_pkg::ST_EMIT_RD;
					end
				end
			end
			sfdr_pkg::ST_NONE: begin
				if (slot_free) begin
					ld_out  = 1'b1;
					state_d = sfdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfdr_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfdr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Parse and output payload registers.
	always_ff @(posedge clk) begin
		len_q <= len_d;
		ck_q  <= ck_d;
		off_q <= off_d;
		sum_q <= sum_d;
		if (s_acc) begin
			dropped_q <= (s_tuser == sfdr_pkg::ACT_PUSH) && full;
		end
		if (ld_out) begin
			out_kind_q <= ld_kind;
			out_byte_q <= (ld_kind == sfdr_pkg::KIND_FRAME) ? rdata : '0;
			out_last_q <= ld_last;
			out_len_q  <= (ld_kind == sfdr_pkg::KIND_FRAME) ? len_q : '0;
			out_drop_q <= dropped_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_drop_q, out_len_q, out_byte_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

endmodule

`default_nettype wire

>>> tb/sv/sfdr_frame_checker.sv
// Watches the three channels of the deframer, predicts every result from
// the accepted input transfers and compares the result stream against it.
module sfdr_frame_checker #(
	parameter int unsigned BUF_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	output int          err_count,
	output int          pending,
	output int          ring_fill,
	output int          results_checked,
	output int          frames_found
);

	import sfdr_pkg::*;

	// One expected transfer on the result side.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] fbyte;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic              dropped;
	} frame_out_t;

	frame_out_t frame_out_q[$];

	// Private copy of the ring buffer and the registers.
	logic [7:0] ring [BUF_DEPTH];
	int         rd_pos;
	int         wr_pos;
	logic       mode;
	logic [7:0] hdr;
	logic [5:0] min_len;
	logic [5:0] fix_len;

	function automatic int held();
		return (wr_pos + BUF_DEPTH - rd_pos) % BUF_DEPTH;
	endfunction

	function automatic logic [7:0] at(input int off);
		return ring[(rd_pos + off) % BUF_DEPTH];
	endfunction

	function automatic void advance_read(input int n);
		rd_pos = (rd_pos + n) % BUF_DEPTH;
	endfunction

	function automatic bit len_valid(input int n);
		return n >= 2 && n <= BUF_DEPTH - 1 && n <= MAX_LEN;
	endfunction

	// One search for a frame at the read position. A bad header, length or
	// checksum drops one byte; returns the frame length or zero.
	function automatic int find_frame();
		int have;
		int need;
		int n;
		int ck_pos;
		logic [7:0] sum;
		have = held();
		sum = '0;
		if (mode == MODE_VARIABLE) begin
			need = (min_len < 2) ? 2 : int'(min_len);
			if (have < need)
				return 0;
			if (at(0) != hdr) begin
				advance_read(1);
				return 0;
			end
			n = at(1);
			if (!len_valid(n)) begin
				advance_read(1);
				return 0;
			end
			if (have < n)
				return 0;
			ck_pos = n - 1;
		end else begin
			n = fix_len;
			if (have < n || have == 0)
				return 0;
			if (at(0) != hdr) begin
				advance_read(1);
				return 0;
			end
			if (!len_valid(n)) begin
				advance_read(1);
				return 0;
			end
			ck_pos = n - 2;
		end
		for (int i = 0; i < ck_pos; i++)
			sum = sum + at(i);
		if (sum != at(ck_pos)) begin
			advance_read(1);
			return 0;
		end
		return n;
	endfunction

	// Store the pushed byte (unless the ring is full), search once and queue
	// the results that this input transfer causes.
	function automatic void deframe_step(input logic act, input logic [7:0] rx);
		logic       dropped;
		int         n;
		frame_out_t r;
		dropped = 1'b0;
		if (act == ACT_PUSH) begin
			if (held() >= BUF_DEPTH - 1) begin
				dropped = 1'b1;
			end else begin
				ring[wr_pos] = rx;
				wr_pos = (wr_pos + 1) % BUF_DEPTH;
			end
		end
		n = find_frame();
		if (n == 0) begin
			r.kind = KIND_NONE;
			r.fbyte = '0;
			r.last = 1'b1;
			r.len = '0;
			r.dropped = dropped;
			frame_out_q.push_back(r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.kind = KIND_FRAME;
				r.fbyte = at(k);
				r.last = (k == n - 1);
				r.len = LEN_W'(n);
				r.dropped = dropped;
				frame_out_q.push_back(r);
			end
			advance_read(n);
			frames_found++;
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] deframer mismatch on result %0d: %s", $time, results_checked, what);
		err_count++;
	endtask

	// Compare one result transfer with the oldest expectation.
	task automatic check_result();
		frame_out_t want;
		if (frame_out_q.size() == 0) begin
			flag_mismatch("result transfer with nothing expected");
		end else begin
			want = frame_out_q.pop_front();
			if (m_tuser !== want.kind)
				flag_mismatch($sformatf("kind %0b, expected %0b", m_tuser, want.kind));
			if (m_tdata[7:0] !== want.fbyte)
				flag_mismatch($sformatf("frame_byte %h, expected %h", m_tdata[7:0],
					want.fbyte));
			if (m_tdata[13:8] !== want.len)
				flag_mismatch($sformatf("frame_len %0d, expected %0d", m_tdata[13:8],
					want.len));
			if (m_tdata[14] !== want.dropped)
				flag_mismatch($sformatf("byte_dropped %0b, expected %0b", m_tdata[14],
					want.dropped));
			if (m_tdata[15] !== 1'b0)
				flag_mismatch("padding bit of tdata is not zero");
			if (m_tlast !== want.last)
				flag_mismatch($sformatf("frame_last %0b, expected %0b", m_tlast, want.last));
		end
		results_checked++;
	endtask

	initial begin
		err_count = 0;
		results_checked = 0;
		frames_found = 0;
		pending = 0;
		ring_fill = 0;
	end

	// Register writes, input transfers and result transfers, in that order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++)
				ring[i] = '0;
			rd_pos = 0;
			wr_pos = 0;
			mode = MODE_VARIABLE;
			hdr = HEADER_RESET;
			min_len = MIN_LEN_RESET;
			fix_len = FIXED_LEN_RESET;
			frame_out_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_MODE: mode = cfg_data[0];
					REG_HEADER:     hdr = cfg_data;
					REG_MIN_LEN:    min_len = cfg_data[5:0];
					REG_FIXED_LEN:  fix_len = cfg_data[5:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				deframe_step(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		pending = frame_out_q.size();
		ring_fill = held();
	end

endmodule

>>> tb/sv/serial_frame_deframer_ring_tb.sv
// Stimulus and verdict for the serial frame deframer; all checking is done
// by the frame checker that sits beside the block.
module serial_frame_deframer_ring_tb;

	import sfdr_pkg::*;

	localparam int unsigned DEPTH = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_CYCLES = 300;

	// Ways a generated frame can be spoiled.
	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_HEADER,
		FLAW_LENGTH
	} flaw_e;

	// Stall patterns of the result receiver.
	typedef enum int {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_RHYTHM
	} rx_style_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] frame_byte, [13:8] frame_len, [14] byte_dropped
	logic        m_tlast;   // frame_last
	logic        m_tuser;   // [0] kind

	int err_count;
	int pending_results;
	int ring_fill;
	int results_checked;
	int frames_found;

	int items_sent;
	int burst_left;
	bit sender_gaps;
	bit long_hold_req;
	int cycle_count;

	// Register values as last written, used to build frames.
	logic       cur_mode;
	logic [7:0] cur_hdr;
	logic [5:0] cur_min;
	logic [5:0] cur_fix;

	serial_frame_deframer_ring #(
		.BUF_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	sfdr_frame_checker #(
		.BUF_DEPTH(DEPTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.err_count(err_count),
		.pending(pending_results),
		.ring_fill(ring_fill),
		.results_checked(results_checked),
		.frames_found(frames_found)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle limit for the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
			pending_results);
		$display("FAILED: results differ");
		$finish;
	end

	// Result receiver: switches at random among four stall patterns and holds
	// off completely for a long stretch when asked.
	initial begin
		rx_style_e style;
		int        style_left;
		int        hold_left;
		m_tready = 1'b0;
		style = RX_OPEN;
		style_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				if (style_left == 0) begin
					style = rx_style_e'($urandom_range(0, 3));
					style_left = $urandom_range(20, 120);
				end
				style_left--;
				case (style)
					RX_OPEN:   m_tready = 1'b1;
					RX_MOSTLY: m_tready = ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
					default:   m_tready = (style_left % 3 == 0);
				endcase
			end
		end
	end

	// Offer one input transfer and wait until it is taken. Transfers go out
	// in bursts; between bursts the line may go quiet when sender gaps are on.
	task automatic push_item(input logic act, input logic [7:0] val);
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = val;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (sender_gaps) begin
				gap = $urandom_range(0, 6);
				@(negedge clk);
				s_tvalid = 1'b0;
				s_tdata = 8'($urandom_range(0, 255));
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic hold_line();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Let the block go idle, then write all four registers.
	task automatic set_regs(input logic mode, input logic [7:0] hdr, input logic [5:0] minl,
			input logic [5:0] fixl);
		hold_line();
		wait (pending_results == 0);
		write_reg(REG_FRAME_MODE, {7'd0, mode});
		write_reg(REG_HEADER, hdr);
		write_reg(REG_MIN_LEN, {2'b00, minl});
		write_reg(REG_FIXED_LEN, {2'b00, fixl});
		cur_mode = mode;
		cur_hdr = hdr;
		cur_min = minl;
		cur_fix = fixl;
	endtask

	// Build a frame of n bytes for the current registers, optionally spoil
	// it, and push it byte by byte.
	task automatic send_frame(input int n, input flaw_e flaw);
		logic [7:0] frm [0:62];
		logic [7:0] sum;
		logic [7:0] tweak;
		int         ck_at;
		frm[0] = cur_hdr;
		for (int i = 1; i < n; i++)
			frm[i] = 8'($urandom_range(0, 255));
		if (cur_mode == MODE_VARIABLE) begin
			frm[1] = 8'(n);
			ck_at = n - 1;
		end else begin
			ck_at = n - 2;
		end
		sum = '0;
		for (int i = 0; i < ck_at; i++)
			sum = sum + frm[i];
		frm[ck_at] = sum;
		tweak = 8'($urandom_range(1, 255));
		case (flaw)
			FLAW_SUM:    frm[ck_at] = frm[ck_at] ^ tweak;
			FLAW_HEADER: frm[0] = frm[0] ^ tweak;
			FLAW_LENGTH: begin
				if (cur_mode == MODE_VARIABLE) begin
					case ($urandom_range(0, 2))
						0:       frm[1] = 8'd0;
						1:       frm[1] = 8'd1;
						default: frm[1] = 8'($urandom_range(64, 255));
					endcase
				end else begin
					frm[ck_at] = frm[ck_at] ^ tweak;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < n; i++)
			push_item(ACT_PUSH, frm[i]);
	endtask

	// Random traffic: mostly good frames, some spoiled ones, loose bytes
	// and polls.
	task automatic run_mix(input int budget, input int long_max);
		int start;
		int pick;
		int n;
		start = items_sent;
		while (items_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (cur_mode == MODE_FIXED)
				n = cur_fix;
			else if ($urandom_range(0, 15) == 0)
				n = $urandom_range(13, long_max);
			else
				n = $urandom_range(3, 12);
			if (pick < 60)
				send_frame(n, FLAW_NONE);
			else if (pick < 75)
				send_frame(n, flaw_e'($urandom_range(1, 3)));
			else if (pick < 90)
				repeat ($urandom_range(1, 4))
					push_item(ACT_PUSH, 8'($urandom_range(0, 255)));
			else
				repeat ($urandom_range(1, 3))
					push_item(ACT_POLL, 8'($urandom_range(0, 255)));
		end
	endtask

	// Fixed mode with a zero length drops one byte per poll; poll until the
	// ring is empty, then once more on the empty ring.
	task automatic drain_ring();
		set_regs(MODE_FIXED, cur_hdr, cur_min, 6'd0);
		hold_line();
		while (ring_fill != 0) begin
			push_item(ACT_POLL, 8'($urandom_range(0, 255)));
			hold_line();
		end
		push_item(ACT_POLL, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_MODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_POLL;
		items_sent = 0;
		burst_left = 0;
		sender_gaps = 1'b1;
		long_hold_req = 1'b0;
		cur_mode = MODE_VARIABLE;
		cur_hdr = HEADER_RESET;
		cur_min = MIN_LEN_RESET;
		cur_fix = FIXED_LEN_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed traffic at reset settings: poll on an empty ring, two good
		// frames, length bytes below 2 and above 63, a bad checksum, waiting.
		push_item(ACT_POLL, 8'hFF);
		push_item(ACT_PUSH, HEADER_RESET); push_item(ACT_PUSH, 8'h04);
		push_item(ACT_PUSH, 8'h10);        push_item(ACT_PUSH, 8'hBE);
		push_item(ACT_PUSH, HEADER_RESET); push_item(ACT_PUSH, 8'h05);
		push_item(ACT_PUSH, 8'hFF);        push_item(ACT_PUSH, 8'h00);
		push_item(ACT_PUSH, 8'hAE);
		push_item(ACT_PUSH, HEADER_RESET); push_item(ACT_PUSH, 8'h01);
		push_item(ACT_PUSH, 8'h33);        push_item(ACT_PUSH, 8'h44);
		push_item(ACT_PUSH, HEADER_RESET); push_item(ACT_PUSH, 8'hFF);
		push_item(ACT_PUSH, 8'h00);        push_item(ACT_PUSH, 8'h00);
		push_item(ACT_PUSH, HEADER_RESET); push_item(ACT_PUSH, 8'h04);
		push_item(ACT_PUSH, 8'h01);        push_item(ACT_PUSH, 8'h00);
		push_item(ACT_POLL, 8'h00);
		push_item(ACT_POLL, 8'h5A);

		// Variable length, all-ones header, smallest minimum; the receiver
		// holds off early on so the block backs up.
		set_regs(MODE_VARIABLE, 8'hFF, 6'd2, 6'd8);
		long_hold_req = 1'b1;
		run_mix(40, 40);

		// Zero header and a minimum below two, no sender gaps.
		set_regs(MODE_VARIABLE, 8'h00, 6'd0, 6'd3);
		sender_gaps = 1'b0;
		run_mix(30, 20);

		// Longest variable frame with the largest minimum.
		drain_ring();
		set_regs(MODE_VARIABLE, HEADER_RESET, 6'd63, 6'd63);
		sender_gaps = 1'b1;
		send_frame(63, FLAW_NONE);
		push_item(ACT_POLL, 8'h00);

		// Fixed length of two puts the checksum on the header byte itself.
		set_regs(MODE_FIXED, 8'h55, 6'd1, 6'd2);
		repeat (3) push_item(ACT_PUSH, 8'h55);

		// Three-byte fixed frames.
		set_regs(MODE_FIXED, 8'h55, 6'd1, 6'd3);
		run_mix(30, 3);

		// Longest fixed frame on a clean ring.
		drain_ring();
		set_regs(MODE_FIXED, 8'hC3, 6'd1, 6'd63);
		send_frame(63, FLAW_NONE);
		push_item(ACT_POLL, 8'h00);

		hold_line();
		wait (pending_results == 0);
		repeat (32) @(posedge clk);

		$display("Sent %0d input transfers under variable and fixed framing, with good,",
			items_sent);
		$display("spoiled and 63-byte frames; checked %0d results, %0d frames recovered.",
			results_checked, frames_found);
		if (err_count == 0 && pending_results == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
